// ----- rtl/bhts_pkg.sv -----
// Package of the binary heap timer scheduler: item types, codes and states.
// Depends on nothing; used by the scheduler, the checker and the testbench.
`default_nettype none

package bhts_pkg;

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_CREATE  = 2'd1;
  localparam logic [1:0] ACT_DESTROY = 2'd2;

  localparam logic [1:0] EV_FIRED     = 2'd0;
  localparam logic [1:0] EV_ARMED     = 2'd1;
  localparam logic [1:0] EV_CANCELLED = 2'd2;
  localparam logic [1:0] EV_REJECTED  = 2'd3;

  localparam logic [31:0] US_PER_MS  = 32'd1000;
  localparam logic [6:0]  FIRE_LIMIT = 7'd64;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] now;
    logic [5:0]  slot;
    logic [21:0] interval_ms;
    logic        one_shot;
  } in_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [5:0] timer_slot;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    CTX_TICK_RM,
    CTX_TICK_PUSH,
    CTX_DESTROY,
    CTX_CREATE
  } ctx_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DEC,
    S_DPOS,
    S_CR,
    S_TCHK,
    S_TS,
    S_TK,
    S_RM,
    S_RML,
    S_RMK,
    S_UP,
    S_UPP,
    S_UPK,
    S_DN,
    S_DNL,
    S_DNLK,
    S_DNR,
    S_DNRK,
    S_DNDEC,
    S_PLACE,
    S_DONE,
    S_TRE
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/bhts_ram.sv -----
// Simple dual-port synchronous memory with a registered read port.
// Depends on nothing; instanced four times by the scheduler.
`default_nettype none

module bhts_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/binary_heap_timer_scheduler.sv -----
// Top level of the binary heap timer scheduler: sequencer and heap memories.
// Depends on bhts_pkg and bhts_ram.
//
// An item is taken when start_i is high and busy_o is low. A tick item fires
// due timers in heap order, at most FIRE_LIMIT; a create item arms a slot and
// a destroy item cancels one. Each result is shown on res_o for one cycle with
// result_valid_o high; the receiver cannot stall, and res_o.last marks the
// final result of an item. A tick with nothing due gives no result.
// Each item is worked on alone while busy_o is high. The cost is set by the
// single read port of each memory: a sift-up level reads the parent's slot and
// then its deadline, and a sift-down level reads slot and deadline of each child
// in turn. A create sifts the new entry up and a destroy sifts the moved last
// entry; a tick does a due check and, for each fired timer, a removal and, if
// periodic, a re-insertion.
// A reset clears the heap count and the armed flags at once; the memories
// need no clearing, as an entry is read only after it has been written.
`default_nettype none

module binary_heap_timer_scheduler #(
  parameter int SLOTS     = 64,
  parameter int TIME_BITS = 48
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire bhts_pkg::in_t item_i,
  output logic               busy_o,
  output logic               result_valid_o,
  output bhts_pkg::out_t     res_o
);

  import bhts_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = SW + 2;
  localparam int TB = TIME_BITS;

  state_e state_q, state_d;
  ctx_e   ctx_q, ctx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] pos_q, pos_d, e_slot_q, e_slot_d, c_slot_q, c_slot_d;
  logic [SW-1:0] best_q, best_d, bs_q, bs_d, fire_q, fire_d, pend_slot_q, pend_slot_d;
  logic [TB-1:0] e_key_q, e_key_d, bk_q, bk_d, now_q, now_d;
  logic          moved_q, moved_d, first_q, first_d, pend_q, pend_d, once_q, once_d;
  logic [6:0]    nres_q, nres_d;
  logic [5:0]    slot_q, slot_d;
  logic [31:0]   us_q, us_d, per_q, per_d;
  logic [1:0]    act_q, act_d;
  logic [SLOTS-1:0] armed_q, armed_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic          ord_we, dl_we, per_we, hp_we;
  logic [SW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rd;
  logic [SW-1:0] dl_waddr, dl_raddr, per_waddr, per_raddr;
  logic [SW-1:0] hp_waddr, hp_wdata, hp_raddr, hp_rd;
  logic [TB-1:0] dl_wdata, dl_rd;
  logic [31:0]   per_wdata, per_rd;

  logic [SW-1:0] sidx, parent;
  logic          in_range;
  logic [IW-1:0] lc, rc, cnt_ext;
  logic [TB:0]   sum_us, sum_per;
  logic [TB-1:0] key_us, key_per;

  bhts_ram #(.W(SW), .D(SLOTS)) u_ord (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rd)
  );
  bhts_ram #(.W(TB), .D(SLOTS)) u_dl (
    .clk_i, .we_i(dl_we), .waddr_i(dl_waddr), .wdata_i(dl_wdata),
    .raddr_i(dl_raddr), .rdata_o(dl_rd)
  );
  bhts_ram #(.W(32), .D(SLOTS)) u_per (
    .clk_i, .we_i(per_we), .waddr_i(per_waddr), .wdata_i(per_wdata),
    .raddr_i(per_raddr), .rdata_o(per_rd)
  );
  bhts_ram #(.W(SW), .D(SLOTS)) u_hp (
    .clk_i, .we_i(hp_we), .waddr_i(hp_waddr), .wdata_i(hp_wdata),
    .raddr_i(hp_raddr), .rdata_o(hp_rd)
  );

  assign sidx     = SW'(slot_q);
  assign in_range = (32'(slot_q) < 32'(SLOTS));
  assign parent   = SW'((pos_q - 1'b1) >> 1);
  assign lc       = {1'b0, pos_q, 1'b1};
  assign rc       = lc + 1'b1;
  assign cnt_ext  = IW'(cnt_q);
  assign sum_us   = {1'b0, now_q} + (TB + 1)'(us_q);
  assign sum_per  = {1'b0, now_q} + (TB + 1)'(per_q);
  assign key_us   = sum_us[TB] ? {TB{1'b1}} : sum_us[TB-1:0];
  assign key_per  = sum_per[TB] ? {TB{1'b1}} : sum_per[TB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      armed_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q       <= ctx_d;
    pos_q       <= pos_d;
    e_slot_q    <= e_slot_d;
    c_slot_q    <= c_slot_d;
    best_q      <= best_d;
    bs_q        <= bs_d;
    fire_q      <= fire_d;
    pend_slot_q <= pend_slot_d;
    e_key_q     <= e_key_d;
    bk_q        <= bk_d;
    now_q       <= now_d;
    moved_q     <= moved_d;
    first_q     <= first_d;
    once_q      <= once_d;
    nres_q      <= nres_d;
    slot_q      <= slot_d;
    us_q        <= us_d;
    per_q       <= per_d;
    act_q       <= act_d;
    out_q       <= out_d;
  end

  always_comb begin
    state_d = state_q;  ctx_d = ctx_q;  cnt_d = cnt_q;  pos_d = pos_q;
    e_slot_d = e_slot_q;  c_slot_d = c_slot_q;  best_d = best_q;  bs_d = bs_q;
    fire_d = fire_q;  pend_slot_d = pend_slot_q;  e_key_d = e_key_q;  bk_d = bk_q;
    now_d = now_q;  moved_d = moved_q;  first_d = first_q;  pend_d = pend_q;
    once_d = once_q;  nres_d = nres_q;  slot_d = slot_q;  us_d = us_q;
    per_d = per_q;  act_d = act_q;  armed_d = armed_q;
    out_valid_d = 1'b0;  out_d = out_q;
    ord_we = 1'b0;  ord_waddr = pos_q;  ord_wdata = e_slot_q;  ord_raddr = '0;
    dl_we = 1'b0;  dl_waddr = fire_q;  dl_wdata = key_per;  dl_raddr = ord_rd;
    per_we = 1'b0;  per_waddr = sidx;  per_wdata = once_q ? 32'd0 : us_q;
    per_raddr = ord_rd;
    hp_we = 1'b0;  hp_waddr = e_slot_q;  hp_wdata = pos_q;  hp_raddr = sidx;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d  = item_i.action;
          now_d  = TB'(item_i.now);
          slot_d = item_i.slot;
          us_d   = 32'(item_i.interval_ms) * US_PER_MS;
          once_d = item_i.one_shot;
          nres_d = '0;
          pend_d = 1'b0;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        case (act_q)
          ACT_TICK: state_d = S_TCHK;
          ACT_CREATE: begin
            if (!in_range || armed_q[sidx]) begin
              out_valid_d = 1'b1;
              out_d = '{event_res: EV_REJECTED, timer_slot: slot_q, last: 1'b1};
              state_d = S_IDLE;
            end else begin
              state_d = S_CR;
            end
          end
          ACT_DESTROY: begin
            if (!in_range || !armed_q[sidx]) begin
              out_valid_d = 1'b1;
              out_d = '{event_res: EV_REJECTED, timer_slot: slot_q, last: 1'b1};
              state_d = S_IDLE;
            end else begin
              state_d = S_DPOS;
            end
          end
          default: begin
            out_valid_d = 1'b1;
            out_d = '{event_res: EV_REJECTED, timer_slot: slot_q, last: 1'b1};
            state_d = S_IDLE;
          end
        endcase
      end
      S_DPOS: begin
        pos_d = hp_rd;
        ctx_d = CTX_DESTROY;
        state_d = S_RM;
      end
      S_CR: begin
        dl_we = 1'b1;  dl_waddr = sidx;  dl_wdata = key_us;
        per_we = 1'b1;
        armed_d[sidx] = 1'b1;
        e_slot_d = sidx;  e_key_d = key_us;
        pos_d = SW'(cnt_q);  cnt_d = cnt_q + 1'b1;
        first_d = 1'b0;  ctx_d = CTX_CREATE;
        state_d = S_UP;
      end
      S_TCHK: begin
        if (cnt_q == '0 || nres_q == FIRE_LIMIT) begin
          out_valid_d = pend_q;
          out_d = '{event_res: EV_FIRED, timer_slot: 6'(pend_slot_q), last: 1'b1};
          state_d = S_IDLE;
        end else begin
          ord_raddr = '0;
          state_d = S_TS;
        end
      end
      S_TS: begin
        fire_d = ord_rd;
        state_d = S_TK;
      end
      S_TK: begin
        if (now_q < dl_rd) begin
          out_valid_d = pend_q;
          out_d = '{event_res: EV_FIRED, timer_slot: 6'(pend_slot_q), last: 1'b1};
          state_d = S_IDLE;
        end else begin
          out_valid_d = pend_q;
          out_d = '{event_res: EV_FIRED, timer_slot: 6'(pend_slot_q), last: 1'b0};
          pend_d = 1'b1;  pend_slot_d = fire_q;  nres_d = nres_q + 1'b1;
          per_d = per_rd;  pos_d = '0;  ctx_d = CTX_TICK_RM;
          state_d = S_RM;
        end
      end
      S_RM: begin
        if (ctx_q == CTX_DESTROY) begin
          armed_d[sidx] = 1'b0;
        end else begin
          armed_d[fire_q] = 1'b0;
        end
        if (CW'(pos_q) == CW'(cnt_q - 1'b1)) begin
          cnt_d = cnt_q - 1'b1;
          state_d = S_DONE;
        end else begin
          ord_raddr = SW'(cnt_q - 1'b1);
          state_d = S_RML;
        end
      end
      S_RML: begin
        e_slot_d = ord_rd;
        cnt_d = cnt_q - 1'b1;
        state_d = S_RMK;
      end
      S_RMK: begin
        e_key_d = dl_rd;
        first_d = 1'b1;
        state_d = (pos_q == '0) ? S_DN : S_UP;
      end
      S_UP: begin
        if (pos_q == '0) begin
          state_d = S_PLACE;
        end else begin
          ord_raddr = parent;
          state_d = S_UPP;
        end
      end
      S_UPP: begin
        c_slot_d = ord_rd;
        state_d = S_UPK;
      end
      S_UPK: begin
        if (dl_rd <= e_key_q) begin
          state_d = first_q ? S_DN : S_PLACE;
        end else begin
          ord_we = 1'b1;  ord_wdata = c_slot_q;
          hp_we = 1'b1;  hp_waddr = c_slot_q;
          pos_d = parent;  first_d = 1'b0;
          state_d = S_UP;
        end
      end
      S_DN: begin
        best_d = pos_q;  bk_d = e_key_q;  moved_d = 1'b0;
        if (lc >= cnt_ext) begin
          state_d = S_PLACE;
        end else begin
          ord_raddr = lc[SW-1:0];
          state_d = S_DNL;
        end
      end
      S_DNL: begin
        c_slot_d = ord_rd;
        state_d = S_DNLK;
      end
      S_DNLK: begin
        if (dl_rd < bk_q) begin
          best_d = lc[SW-1:0];  bs_d = c_slot_q;  bk_d = dl_rd;  moved_d = 1'b1;
        end
        if (rc < cnt_ext) begin
          ord_raddr = rc[SW-1:0];
          state_d = S_DNR;
        end else begin
          state_d = S_DNDEC;
        end
      end
      S_DNR: begin
        c_slot_d = ord_rd;
        state_d = S_DNRK;
      end
      S_DNRK: begin
        if (dl_rd < bk_q) begin
          best_d = rc[SW-1:0];  bs_d = c_slot_q;  moved_d = 1'b1;
        end
        state_d = S_DNDEC;
      end
      S_DNDEC: begin
        if (!moved_q) begin
          state_d = S_PLACE;
        end else begin
          ord_we = 1'b1;  ord_wdata = bs_q;
          hp_we = 1'b1;  hp_waddr = bs_q;
          pos_d = best_q;
          state_d = S_DN;
        end
      end
      S_PLACE: begin
        ord_we = 1'b1;
        hp_we = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        case (ctx_q)
          CTX_TICK_RM: state_d = S_TRE;
          CTX_TICK_PUSH: state_d = S_TCHK;
          CTX_DESTROY: begin
            out_valid_d = 1'b1;
            out_d = '{event_res: EV_CANCELLED, timer_slot: slot_q, last: 1'b1};
            state_d = S_IDLE;
          end
          default: begin
            out_valid_d = 1'b1;
            out_d = '{event_res: EV_ARMED, timer_slot: slot_q, last: 1'b1};
            state_d = S_IDLE;
          end
        endcase
      end
      S_TRE: begin
        if (per_q != '0) begin
          dl_we = 1'b1;
          armed_d[fire_q] = 1'b1;
          e_slot_d = fire_q;  e_key_d = key_per;
          pos_d = SW'(cnt_q);  cnt_d = cnt_q + 1'b1;
          first_d = 1'b0;  ctx_d = CTX_TICK_PUSH;
          state_d = S_UP;
        end else begin
          state_d = S_TCHK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = out_valid_q;
  assign res_o          = out_q;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("item accepted but block not busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(SLOTS))
    else $error("heap count beyond slot count");

  a_armed_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> $countones(armed_q) == 32'(cnt_q))
    else $error("armed flags disagree with heap count");

endmodule

`default_nettype wire

// ----- tb/timer_heap_checker.sv -----
// Checker for the binary heap timer scheduler: keeps its own timer heap, works
// out the events each accepted item causes and compares them with the results.
// Depends on bhts_pkg.
`timescale 1ns / 1ps

module timer_heap_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           busy_i,
  input  wire bhts_pkg::in_t  item_i,
  input  wire logic           result_valid_i,
  input  wire bhts_pkg::out_t res_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import bhts_pkg::*;

  localparam int NSLOT = 64;
  localparam logic [47:0] TOP_TIME = '1;

  logic [5:0]  order_q [NSLOT];
  int          count_q;
  logic [47:0] due_q [NSLOT];
  logic [31:0] period_q [NSLOT];
  int          where_q [NSLOT];
  bit          armed_q [NSLOT];
  out_t        events_q [$];
  int          mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = events_q.size();

  function automatic logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? TOP_TIME : s[47:0];
  endfunction

  function automatic logic [47:0] key(int p);
    return due_q[order_q[p]];
  endfunction

  task automatic swap(int a, int b);
    logic [5:0] x;
    x = order_q[a];
    order_q[a] = order_q[b];
    order_q[b] = x;
    where_q[order_q[a]] = a;
    where_q[order_q[b]] = b;
  endtask

  task automatic rise(int p);
    int up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (key(up) <= key(p)) break;
      swap(up, p);
      p = up;
    end
  endtask

  task automatic sink(int p);
    int l;
    int best;
    forever begin
      l = 2 * p + 1;
      best = p;
      if (l < count_q && key(l) < key(best)) best = l;
      if (l + 1 < count_q && key(l + 1) < key(best)) best = l + 1;
      if (best == p) break;
      swap(p, best);
      p = best;
    end
  endtask

  task automatic arm(logic [5:0] s);
    where_q[s] = count_q;
    armed_q[s] = 1'b1;
    order_q[count_q] = s;
    count_q++;
    rise(count_q - 1);
  endtask

  task automatic disarm(int p);
    logic [5:0] s;
    s = order_q[p];
    if (p != count_q - 1) begin
      order_q[p] = order_q[count_q - 1];
      where_q[order_q[p]] = p;
    end
    count_q--;
    if (p < count_q) begin
      if (p > 0 && key(p) < key((p - 1) / 2)) rise(p);
      else sink(p);
    end
    armed_q[s] = 1'b0;
  endtask

  task automatic predict(in_t it);
    logic [5:0]  s;
    logic [31:0] us;
    int          n;
    us = {10'd0, it.interval_ms} * US_PER_MS;
    case (it.action)
      ACT_TICK: begin
        n = 0;
        while (count_q > 0 && n < int'(FIRE_LIMIT)) begin
          s = order_q[0];
          if (it.now < due_q[s]) break;
          disarm(0);
          if (period_q[s] != 0) begin
            due_q[s] = add_sat(it.now, period_q[s]);
            arm(s);
          end
          events_q.push_back('{EV_FIRED, s, 1'b0});
          n++;
        end
        if (n > 0) events_q[events_q.size() - 1].last = 1'b1;
      end
      ACT_CREATE: begin
        if (armed_q[it.slot]) begin
          events_q.push_back('{EV_REJECTED, it.slot, 1'b1});
        end else begin
          due_q[it.slot] = add_sat(it.now, us);
          period_q[it.slot] = it.one_shot ? 32'd0 : us;
          arm(it.slot);
          events_q.push_back('{EV_ARMED, it.slot, 1'b1});
        end
      end
      ACT_DESTROY: begin
        if (!armed_q[it.slot]) begin
          events_q.push_back('{EV_REJECTED, it.slot, 1'b1});
        end else begin
          disarm(where_q[it.slot]);
          events_q.push_back('{EV_CANCELLED, it.slot, 1'b1});
        end
      end
      default: events_q.push_back('{EV_REJECTED, it.slot, 1'b1});
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      count_q = 0;
      mismatches <= 0;
      for (int i = 0; i < NSLOT; i++) armed_q[i] = 1'b0;
    end else begin
      if (result_valid_i) begin
        if (events_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", res_i);
        end else begin
          want = events_q.pop_front();
          if (res_i.event_res !== want.event_res || res_i.timer_slot !== want.timer_slot
              || res_i.last !== want.last) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch: expected %p, got %p", want, res_i);
          end
        end
      end
      if (start_i && !busy_i) predict(item_i);
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the testbench: drives tick, create, destroy and invalid items into
// the DUT and gives the verdict. Depends on bhts_pkg, the DUT and the checker.
`timescale 1ns / 1ps

module testbench;
  import bhts_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  in_t   item_i;
  logic  busy_o;
  logic  result_valid_o;
  out_t  res_o;
  int    fail_count;
  int    pending;
  int    quiet_cycles;
  int    gap_pct;
  logic [47:0] clock_us;

  binary_heap_timer_scheduler dut (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .result_valid_o, .res_o
  );

  timer_heap_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .item_i,
    .result_valid_i(result_valid_o), .res_i(res_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send(logic [1:0] act, logic [47:0] t, logic [5:0] s,
                      logic [21:0] ms, logic once);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= '{act, t, s, ms, once};
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic random_item();
    int r;
    logic [21:0] ms;
    r = $urandom_range(99);
    ms = ($urandom_range(9) == 0) ? 22'($urandom) : 22'($urandom_range(20));
    if (r < 5) clock_us = 48'({$urandom, $urandom});
    else clock_us = clock_us + 48'($urandom_range(30000));
    if (r < 40) send(ACT_TICK, clock_us, 6'($urandom), ms, 1'($urandom));
    else if (r < 75) send(ACT_CREATE, clock_us, 6'($urandom_range(15)), ms, 1'($urandom));
    else if (r < 85) send(ACT_CREATE, clock_us, 6'($urandom), ms, 1'($urandom));
    else if (r < 98) send(ACT_DESTROY, clock_us, 6'($urandom_range(15)), ms, 1'($urandom));
    else send(2'd3, clock_us, 6'($urandom), ms, 1'($urandom));
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    gap_pct = 7;
    quiet_cycles = 0;
    clock_us = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(ACT_TICK, 48'd0, 6'd0, 22'd0, 1'b0);
    send(ACT_DESTROY, 48'd0, 6'd5, 22'd0, 1'b0);
    send(ACT_CREATE, 48'd0, 6'd0, 22'd0, 1'b0);
    send(ACT_CREATE, 48'd0, 6'd0, 22'd3, 1'b0);
    send(ACT_CREATE, 48'hFFFF_FFFF_FF00, 6'd63, 22'h3FFFFF, 1'b0);
    send(ACT_CREATE, 48'd10, 6'd1, 22'd1, 1'b1);
    send(ACT_CREATE, 48'd10, 6'd2, 22'd1, 1'b0);
    send(ACT_CREATE, 48'd10, 6'd3, 22'd2, 1'b0);
    send(2'd3, 48'd0, 6'd42, 22'd0, 1'b1);
    send(ACT_TICK, 48'd5000, 6'd0, 22'd0, 1'b0);
    send(ACT_DESTROY, 48'd0, 6'd3, 22'd0, 1'b0);
    send(ACT_DESTROY, 48'd0, 6'd3, 22'd0, 1'b0);
    send(ACT_TICK, 48'hFFFF_FFFF_FFFF, 6'h3F, 22'h3FFFFF, 1'b1);
    send(ACT_TICK, 48'hFFFF_FFFF_FFFF, 6'd0, 22'd0, 1'b0);
    for (int i = 0; i < 64; i++) send(ACT_DESTROY, 48'd0, 6'(i), 22'd0, 1'b0);
    for (int i = 0; i < 64; i++) send(ACT_CREATE, 48'd100, 6'(i), 22'($urandom_range(3)), 1'($urandom));
    send(ACT_TICK, 48'd100_000, 6'd0, 22'd0, 1'b0);
    send(ACT_TICK, 48'd200_000, 6'd0, 22'd0, 1'b0);
    for (int i = 0; i < 64; i++) send(ACT_DESTROY, 48'd0, 6'(i), 22'd0, 1'b0);

    clock_us = '0;
    for (int i = 0; i < 270; i++) begin
      gap_pct = (i < 90) ? 7 : (i < 180) ? 68 : 0;
      random_item();
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- binary_heap_timer_scheduler.f -----
rtl/bhts_pkg.sv
rtl/bhts_ram.sv
rtl/binary_heap_timer_scheduler.sv
tb/timer_heap_checker.sv
tb/testbench.sv
